[hw/rtl/integer_to_decimal_ascii_top_defines.svh]
// Assertion macros shared by the decimal conversion RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef INTEGER_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define INT2DEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define INT2DEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/int2dec_pkg.sv]
package int2dec_pkg;

  // Field widths.
  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int TOTAL_W   = 4;
  localparam int BIT_CNT_W = 5;

  // A 32-bit magnitude never needs more than ten decimal digits.
  localparam int NUM_BCD            = 10;
  localparam int DEFAULT_MAX_DIGITS = 10;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    logic               signed_mode;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_code;
    logic               last_char;
    logic [TOTAL_W-1:0] char_total;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

endpackage

[hw/rtl/integer_to_decimal_ascii_top.sv]
// Sequence: after the input transfer, 32 bit-serial double-dabble steps run, then the
// first character is loaded into the output register once the output can take it.
// Each number gives N = 1 to 11 characters, output at one character per cycle unless
// out_ready stalls it; a new number is taken only after its last character is loaded.
// Reset: synchronous, active low; it clears the control state and the output valid.
`include "integer_to_decimal_ascii_top_defines.svh"

module integer_to_decimal_ascii_top
  import int2dec_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Digits kept: the low MAX_DIGITS digits, never more than a 32-bit value can have.
  localparam int K     = (MAX_DIGITS < NUM_BCD) ? MAX_DIGITS : NUM_BCD;
  localparam int LEN_W = $clog2(K + 1);
  localparam int IDX_W = (K > 1) ? $clog2(K) : 1;

  state_t                   state_r, state_nxt;
  logic [VALUE_W-1:0]       mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [BIT_CNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [K-1:0][3:0]        bcd_r, bcd_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic                     minus_pend_r, minus_pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic [K-1:0][3:0]        adj;
  logic [K-1:0][3:0]        shifted;
  logic                     carry_out;
  logic [TOTAL_W-1:0]       total;
  logic                     load;
  logic                     conv_last;
  logic                     out_last;
  logic                     total_ok;

  // Double-dabble correction: add three to every digit of five or more.
  always_comb begin
    for (int i = 0; i < K; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  // Shift the corrected digits left by one bit, the next magnitude bit enters at the bottom.
  always_comb begin
    shifted[0] = {adj[0][2:0], mag_r[VALUE_W-1]};
    for (int i = 1; i < K; i++) begin
      shifted[i] = {adj[i][2:0], adj[i-1][3]};
    end
    carry_out = adj[K-1][3];
  end

  // Character count: the sign plus the significant digits, at least one digit.
  assign total = TOTAL_W'(neg_r) + ((len_r == '0) ? TOTAL_W'(1) : TOTAL_W'(len_r));
  assign load  = !out_valid_r || out_ready;

  // Next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    bit_cnt_nxt    = bit_cnt_r;
    bcd_nxt        = bcd_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    minus_pend_nxt = minus_pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt        = in_data.signed_mode && in_data.value_bits[VALUE_W-1];
          mag_nxt        = neg_nxt ? (VALUE_W'(0) - in_data.value_bits) : in_data.value_bits;
          minus_pend_nxt = neg_nxt;
          bit_cnt_nxt    = '0;
          bcd_nxt        = '0;
          len_nxt        = '0;
          state_nxt      = ST_CONV;
        end
      end

      ST_CONV: begin
        bcd_nxt     = shifted;
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        // The value at most doubles per step, so the length grows by one at most.
        // A bit shifted out of the top digit means high digits are dropped.
        priority if (carry_out || len_r == LEN_W'(K)) begin
          len_nxt = LEN_W'(K);
        end else if (shifted[IDX_W'(len_r)] != 4'd0) begin
          len_nxt = len_r + LEN_W'(1);
        end else begin
          len_nxt = len_r;
        end
        if (bit_cnt_r == '1) begin
          pos_nxt   = (len_nxt == '0) ? '0 : IDX_W'(len_nxt - LEN_W'(1));
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (minus_pend_r) begin
            out_nxt.char_code  = CHAR_MINUS;
            out_nxt.last_char  = 1'b0;
            out_nxt.char_total = '0;
            minus_pend_nxt     = 1'b0;
          end else begin
            out_nxt.char_code  = CHAR_ZERO + {4'd0, bcd_r[pos_r]};
            out_nxt.last_char  = (pos_r == '0);
            out_nxt.char_total = (pos_r == '0) ? total : '0;
            pos_nxt            = pos_r - IDX_W'(1);
            if (pos_r == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    bcd_r        <= bcd_nxt;
    len_r        <= len_nxt;
    pos_r        <= pos_nxt;
    minus_pend_r <= minus_pend_nxt;
    out_r        <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Terms used by the checks below.
  assign conv_last = (state_r == ST_CONV) && (bit_cnt_r == '1);
  assign out_last  = out_valid && out_data.last_char;
  assign total_ok  = (out_data.char_total != '0) && (out_data.char_total <= TOTAL_W'(K + 1));

  // Checks on the conversion sequence.
  `INT2DEC_ASSERT_NXT(a_start_conv, in_valid && in_ready, state_r == ST_CONV, "input not taken")
  `INT2DEC_ASSERT_NXT(a_conv_done, conv_last, state_r == ST_EMIT, "conversion overran 32 steps")
  `INT2DEC_ASSERT_IMP(a_len_range, state_r != ST_IDLE, len_r <= LEN_W'(K), "length too large")
  `INT2DEC_ASSERT_IMP(a_total_range, out_last, total_ok, "character total out of range")

endmodule
